@@ rtl/pasr_pkg.sv @@
// Shared types and constants for the PGAS access route and split block.
// No dependencies; every other file in rtl/ imports this package.
package pasr_pkg;

    localparam int LINE_BYTES = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int STRIPES    = 4096;
    localparam int MAX_NODES  = 256;

    localparam int LINE_SH  = $clog2(LINE_BYTES);
    localparam int STRIPE_W = $clog2(STRIPES);
    localparam int NC_W     = $clog2(MAX_NODES) + 1;
    localparam int Q_W      = $clog2(MAX_NODES) + 1;
    localparam int FS_W     = $clog2(LINE_BYTES) + 1;
    localparam int SS_W     = $clog2(LINE_BYTES);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_BUSY     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_NODES = 2'd2,
        REG_LOCAL = 2'd3
    } t_cfg_reg;

    // One item as it moves through the node division stages.
    typedef struct packed {
        logic                valid;
        t_status             status;
        logic [6:0]          width;
        logic [FS_W-1:0]     fsize;
        logic [SS_W-1:0]     ssize;
        logic [STRIPE_W-1:0] stripe;
        logic [63:0]         off;
        logic [63:0]         rem;
        logic [Q_W-1:0]      quo;
    } t_item;

    // Status of the background node size divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/pgas_access_route_and_split_core.sv @@
// Top level of the PGAS access route and split block: APB registers,
// check stages, node division pipeline and output register. Uses pasr_pkg,
// pasr_cfg_div and pasr_div_stage.
//
// One request is taken in every cycle in which start is high and busy is
// low, and its single result appears on the o_ ports with o_done high.
// The pipeline is two check stages, nine node division stages (one
// quotient bit each), a node fix-up stage and the output register. The
// receiver cannot stall, so busy is high only while the node size is being
// recomputed after reset is released and after every configuration write:
// the one-bit-per-cycle divider of the region size by the node count runs,
// then a register settles the derived boundaries. Configuration registers
// are 64-bit APB registers at byte addresses 0 (region base), 8 (region
// size), 16 (node count) and 24 (local node).
module pgas_access_route_and_split_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic                          i_access_class,
    input  logic [63:0]                   i_address,
    input  logic [7:0]                    i_access_width,
    input  logic [7:0]                    i_source_size,
    input  logic                          i_already_locked,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    // result channel
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [7:0]                    o_owner_node,
    output logic                          o_is_remote,
    output logic [1:0]                    o_segment_count,
    output logic [63:0]                   o_first_node_offset,
    output logic [6:0]                    o_first_bytes,
    output logic [63:0]                   o_second_node_offset,
    output logic [5:0]                    o_second_bytes,
    output logic [11:0]                   o_first_stripe,
    output logic [11:0]                   o_second_stripe,
    output logic [1:0]                    o_stripe_count
);
    import pasr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers and the values derived from them.
    // ------------------------------------------------------------------
    logic [63:0]     r_base;
    logic [63:0]     r_size;
    logic [NC_W-1:0] r_nodes;
    logic [7:0]      r_local;
    logic            r_kick;
    logic            r_tail;
    logic [64:0]     r_rend;
    logic [63:0]     r_last_off;
    logic            r_nc_bad;
    logic            w_cfg_wr;
    t_cfg_reg        w_reg;
    t_div_stat       w_div;
    logic [63:0]     w_node_span;
    logic [NC_W-1:0] w_div_rem;

    assign pready   = 1'b1;
    assign w_reg    = t_cfg_reg'(paddr[4:3]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_size  <= '0;
            r_nodes <= NC_W'(1);
            r_local <= '0;
            r_kick  <= 1'b0;
            r_tail  <= 1'b1;
        end else begin
            r_kick <= w_cfg_wr;
            r_tail <= w_div.busy;
            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_BASE:  r_base  <= pwdata;
                    REG_SIZE:  r_size  <= pwdata;
                    REG_NODES: r_nodes <= pwdata[NC_W-1:0];
                    REG_LOCAL: r_local <= pwdata[7:0];
                    default:   r_local <= r_local;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_BASE:  prdata = r_base;
            REG_SIZE:  prdata = r_size;
            REG_NODES: prdata = 64'(r_nodes);
            REG_LOCAL: prdata = 64'(r_local);
            default:   prdata = '0;
        endcase
    end

    pasr_cfg_div u_cfg_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_kick),
        .i_dividend  (r_size),
        .i_divisor   (r_nodes),
        .o_stat      (w_div),
        .o_quotient  (w_node_span),
        .o_remainder (w_div_rem)
    );

    // The last node starts at (node_count - 1) * node size, which equals
    // the region size - remainder - node size.
    always_ff @(posedge i_clk) begin
        r_rend     <= {1'b0, r_base} + {1'b0, r_size};
        r_last_off <= r_size - 64'(w_div_rem) - w_node_span;
        r_nc_bad   <= (r_nodes == '0) || (r_nodes > NC_W'(MAX_NODES))
                      || (w_node_span == '0);
    end

    assign busy = r_kick || w_div.busy || r_tail;

    // ------------------------------------------------------------------
    // Stage 1: request checks, end address, offset, line split, stripe.
    // ------------------------------------------------------------------
    logic                w_accept;
    t_status             w_pre;
    logic [FS_W-1:0]     w_room;
    logic [FS_W-1:0]     w_fsize;

    logic                r_s1_valid;
    t_status             r_s1_pre;
    logic                r_s1_wbad;
    logic [63:0]         r_s1_addr;
    logic [64:0]         r_s1_aend;
    logic [63:0]         r_s1_off;
    logic [6:0]          r_s1_width;
    logic [FS_W-1:0]     r_s1_fsize;
    logic [SS_W-1:0]     r_s1_ssize;
    logic [STRIPE_W-1:0] r_s1_stripe;

    assign w_accept = start && !busy;

    always_comb begin
        priority if (i_req_type && (i_source_size != i_access_width)) begin
            w_pre = ST_INVALID;
        end else if (i_already_locked) begin
            w_pre = ST_BUSY;
        end else if (i_access_class != i_req_type) begin
            w_pre = ST_INVALID;
        end else begin
            w_pre = ST_OK;
        end
    end

    assign w_room  = FS_W'(LINE_BYTES) - FS_W'(i_address[LINE_SH-1:0]);
    assign w_fsize = (i_access_width < 8'(w_room)) ? FS_W'(i_access_width) : w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_pre    <= w_pre;
        r_s1_wbad   <= (i_access_width == '0) || (i_access_width > 8'(MAX_WIDTH));
        r_s1_addr   <= i_address;
        r_s1_aend   <= {1'b0, i_address} + 65'(i_access_width);
        r_s1_off    <= i_address - r_base;
        r_s1_width  <= i_access_width[6:0];
        r_s1_fsize  <= w_fsize;
        r_s1_ssize  <= SS_W'(i_access_width - 8'(w_fsize));
        r_s1_stripe <= i_address[LINE_SH +: STRIPE_W];
    end

    // ------------------------------------------------------------------
    // Stage 2: region classification and the final check status.
    // ------------------------------------------------------------------
    t_status w_s2_status;
    t_item   r_s2;

    always_comb begin
        priority if (r_s1_pre != ST_OK) begin
            w_s2_status = r_s1_pre;
        end else if (r_s1_wbad) begin
            w_s2_status = ST_OVERFLOW;
        end else if (r_s1_aend[64] || r_rend[64]) begin
            w_s2_status = ST_OVERFLOW;
        end else if ((r_size == '0) || (r_s1_aend[63:0] <= r_base)
                     || (r_s1_addr >= r_rend[63:0]) || (r_s1_addr < r_base)
                     || (r_s1_aend[63:0] > r_rend[63:0])) begin
            w_s2_status = ST_RANGE;
        end else if (r_nc_bad) begin
            w_s2_status = ST_INVALID;
        end else begin
            w_s2_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= r_s1_valid;
        end
        r_s2.status <= w_s2_status;
        r_s2.width  <= r_s1_width;
        r_s2.fsize  <= r_s1_fsize;
        r_s2.ssize  <= r_s1_ssize;
        r_s2.stripe <= r_s1_stripe;
        r_s2.off    <= r_s1_off;
        r_s2.rem    <= r_s1_off;
        r_s2.quo    <= '0;
    end

    // ------------------------------------------------------------------
    // Division stages: node = offset / node size, one bit per stage, most
    // significant first. The remainder is the offset inside the node.
    // ------------------------------------------------------------------
    t_item w_chain [Q_W+1];

    assign w_chain[0] = r_s2;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        pasr_div_stage #(
            .K (Q_W - 1 - g)
        ) u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_item      (w_chain[g]),
            .i_node_span (w_node_span),
            .o_item      (w_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Node fix-up: an offset in the remainder past the last full node
    // belongs to the last node, which ends at the region end. Any other
    // node must hold the whole access.
    // ------------------------------------------------------------------
    t_item               w_d;
    logic                w_clamp;
    logic                w_last;
    logic                w_cross;

    logic                r_s12_valid;
    t_status             r_s12_status;
    logic [Q_W-1:0]      r_s12_node;
    logic [63:0]         r_s12_noff;
    logic [FS_W-1:0]     r_s12_fsize;
    logic [SS_W-1:0]     r_s12_ssize;
    logic [STRIPE_W-1:0] r_s12_stripe;

    assign w_d     = w_chain[Q_W];
    assign w_clamp = (w_d.quo >= r_nodes);
    assign w_last  = w_clamp || (w_d.quo == (r_nodes - NC_W'(1)));
    assign w_cross = ({1'b0, w_d.rem} + 65'(w_d.width)) > {1'b0, w_node_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_valid <= 1'b0;
        end else begin
            r_s12_valid <= w_d.valid;
        end
        if ((w_d.status == ST_OK) && !w_last && w_cross) begin
            r_s12_status <= ST_RANGE;
        end else begin
            r_s12_status <= w_d.status;
        end
        r_s12_node   <= w_clamp ? (r_nodes - NC_W'(1)) : w_d.quo;
        r_s12_noff   <= w_clamp ? (w_d.off - r_last_off) : w_d.rem;
        r_s12_fsize  <= w_d.fsize;
        r_s12_ssize  <= w_d.ssize;
        r_s12_stripe <= w_d.stripe;
    end

    // ------------------------------------------------------------------
    // Output register. Error results carry only the status.
    // ------------------------------------------------------------------
    logic                r_o_done;
    logic                w_ok;
    logic                w_two;
    logic [STRIPE_W-1:0] w_stripe1;

    assign w_ok      = (r_s12_status == ST_OK);
    assign w_two     = (r_s12_ssize != '0);
    assign w_stripe1 = r_s12_stripe + STRIPE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_done <= 1'b0;
        end else begin
            r_o_done <= r_s12_valid;
        end
        o_status             <= r_s12_status;
        o_owner_node         <= w_ok ? r_s12_node[7:0] : '0;
        o_is_remote          <= w_ok && (r_s12_node != {1'b0, r_local});
        o_segment_count      <= !w_ok ? 2'd0 : (w_two ? 2'd2 : 2'd1);
        o_first_node_offset  <= w_ok ? r_s12_noff : '0;
        o_first_bytes        <= w_ok ? r_s12_fsize : '0;
        o_first_stripe       <= w_ok ? r_s12_stripe : '0;
        o_second_node_offset <= (w_ok && w_two) ? (r_s12_noff + 64'(r_s12_fsize)) : '0;
        o_second_bytes       <= (w_ok && w_two) ? r_s12_ssize : '0;
        o_second_stripe      <= (w_ok && w_two) ? w_stripe1 : '0;
        o_stripe_count       <= !w_ok ? 2'd0
                              : ((w_two && (w_stripe1 != r_s12_stripe)) ? 2'd2 : 2'd1);
    end

    assign o_done = r_o_done;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##13 o_done)
        else $error("accepted item did not produce a result on time");

    a_err_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> ((o_segment_count == 2'd0)
        && (o_stripe_count == 2'd0) && (o_first_bytes == '0)))
        else $error("error result carries segment data");

    a_seg_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_OK)) |->
        ((o_second_bytes != '0) == (o_segment_count == 2'd2)))
        else $error("segment count disagrees with second segment size");

    a_cfg_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> busy)
        else $error("block not busy after a configuration write");
`endif

endmodule

@@ rtl/pasr_cfg_div.sv @@
// Iterative divider that derives the node size from the region registers.
// Depends on pasr_pkg; one quotient bit per cycle.
module pasr_cfg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_dividend,
    input  logic [pasr_pkg::NC_W-1:0] i_divisor,
    output pasr_pkg::t_div_stat       o_stat,
    output logic [63:0]               o_quotient,
    output logic [pasr_pkg::NC_W-1:0] o_remainder
);
    import pasr_pkg::*;

    localparam int CNT_W = $clog2(65);

    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_q;
    logic [NC_W-1:0]  r_rem;
    logic [NC_W:0]    w_rem_sh;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_q[63]};
    assign w_ge     = (w_rem_sh >= {1'b0, i_divisor});

    // Reset starts a pass over the reset register values (region size zero).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_W'(64);
            r_q   <= '0;
            r_rem <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(64);
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_q   <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? NC_W'(w_rem_sh - {1'b0, i_divisor}) : w_rem_sh[NC_W-1:0];
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = (r_cnt == CNT_W'(1));
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

@@ rtl/pasr_div_stage.sv @@
// One restoring division stage of the node selection pipeline.
// Depends on pasr_pkg; resolves quotient bit K of offset / node size.
module pasr_div_stage #(
    parameter int K = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pasr_pkg::t_item i_item,
    input  logic [63:0]     i_node_span,
    output pasr_pkg::t_item o_item
);
    import pasr_pkg::*;

    logic [63+Q_W:0] w_dsh;
    logic            w_ge;
    t_item           r_item;
    t_item           n_item;

    assign w_dsh = {{Q_W{1'b0}}, i_node_span} << K;
    assign w_ge  = ({{Q_W{1'b0}}, i_item.rem} >= w_dsh);

    always_comb begin
        n_item = i_item;
        if (w_ge) begin
            n_item.rem    = i_item.rem - w_dsh[63:0];
            n_item.quo[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else begin
            r_item.valid <= i_item.valid;
        end
        r_item.status <= n_item.status;
        r_item.width  <= n_item.width;
        r_item.fsize  <= n_item.fsize;
        r_item.ssize  <= n_item.ssize;
        r_item.stripe <= n_item.stripe;
        r_item.off    <= n_item.off;
        r_item.rem    <= n_item.rem;
        r_item.quo    <= n_item.quo;
    end

    assign o_item = r_item;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for pgas_access_route_and_split_core.
// It drives requests and APB register writes, predicts each result in place
// and checks the result channel. Depends on rtl/pasr_pkg.sv and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import pasr_pkg::*;

    // Expected contents of one result item, in the order of the o_ ports.
    typedef struct packed {
        t_status     status;
        logic [7:0]  node;
        logic        remote;
        logic [1:0]  segs;
        logic [63:0] off0;
        logic [6:0]  size0;
        logic [63:0] off1;
        logic [5:0]  size1;
        logic [11:0] stripe0;
        logic [11:0] stripe1;
        logic [1:0]  nstripes;
    } t_route;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = 1'b0;
    logic        i_access_class = 1'b0;
    logic [63:0] i_address = '0;
    logic [7:0]  i_access_width = '0;
    logic [7:0]  i_source_size = '0;
    logic        i_already_locked = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_owner_node;
    logic        o_is_remote;
    logic [1:0]  o_segment_count;
    logic [63:0] o_first_node_offset;
    logic [6:0]  o_first_bytes;
    logic [63:0] o_second_node_offset;
    logic [5:0]  o_second_bytes;
    logic [11:0] o_first_stripe;
    logic [11:0] o_second_stripe;
    logic [1:0]  o_stripe_count;

    // The testbench's own copy of the configuration registers.
    logic [63:0] cfg_base = '0;
    logic [63:0] cfg_size = '0;
    logic [8:0]  cfg_nodes = 9'd1;
    logic [7:0]  cfg_local = '0;

    t_route pending_routes[$];
    int     errors = 0;

    pgas_access_route_and_split_core u_top (.*);

    always #6 i_clk = ~i_clk;

    // Computes the routing result of one request from the current registers.
    function automatic t_route predict_route(logic req, logic cls, logic [63:0] addr,
                                             logic [7:0] w, logic [7:0] src, logic lk);
        t_route      r;
        t_status     st;
        logic [64:0] aend;
        logic [64:0] rend;
        logic [63:0] nsz;
        logic [63:0] node;
        logic [63:0] nbase;
        logic [63:0] nend;
        logic [6:0]  fs;
        r    = '0;
        st   = ST_OK;
        nsz  = '0;
        aend = {1'b0, addr} + w;
        rend = {1'b0, cfg_base} + cfg_size;
        // The request checks come first, in a fixed priority.
        if (req && src != w) st = ST_INVALID;
        else if (lk) st = ST_BUSY;
        else if (cls != req) st = ST_INVALID;
        else if (w == 0 || w > MAX_WIDTH) st = ST_OVERFLOW;
        else if (aend[64] || rend[64]) st = ST_OVERFLOW;
        else if (cfg_size == 0 || aend[63:0] <= cfg_base || addr >= rend[63:0]) st = ST_RANGE;
        else if (addr < cfg_base || aend[63:0] > rend[63:0]) st = ST_RANGE;
        if (st == ST_OK) begin
            if (cfg_nodes == 0 || cfg_nodes > MAX_NODES) st = ST_INVALID;
            else begin
                nsz = cfg_size / cfg_nodes;
                if (nsz == 0) st = ST_INVALID;
            end
        end
        if (st == ST_OK) begin
            // The last node absorbs the remainder of the division.
            node = (addr - cfg_base) / nsz;
            if (node >= cfg_nodes) node = cfg_nodes - 1;
            nbase = cfg_base + node * nsz;
            nend  = (node + 1 == cfg_nodes) ? rend[63:0] : nbase + nsz;
            if (aend[63:0] > nend) st = ST_RANGE;
        end
        r.status = st;
        if (st != ST_OK) return r;
        fs = 7'd64 - addr[5:0];
        if (w < fs) fs = w[6:0];
        r.node     = node[7:0];
        r.remote   = (node[7:0] != cfg_local);
        r.off0     = addr - nbase;
        r.size0    = fs;
        r.stripe0  = addr[17:6];
        r.segs     = 2'd1;
        r.nstripes = 2'd1;
        if (w != fs) begin
            r.segs    = 2'd2;
            r.off1    = addr + fs - nbase;
            r.size1   = 6'(w - 8'(fs));
            r.stripe1 = 12'((addr + 64'(fs)) >> 6);
            if (r.stripe1 != r.stripe0) r.nstripes = 2'd2;
        end
        return r;
    endfunction

    // Result checker: every strobed result must match the oldest prediction.
    task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_route e;
        if (i_rst_n && o_done) begin
            if (pending_routes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, o_status);
                errors++;
            end else begin
                e = pending_routes.pop_front();
                check_field("status", e.status, o_status);
                check_field("owner_node", e.node, o_owner_node);
                check_field("is_remote", e.remote, o_is_remote);
                check_field("segment_count", e.segs, o_segment_count);
                check_field("first_node_offset", e.off0, o_first_node_offset);
                check_field("first_bytes", e.size0, o_first_bytes);
                check_field("second_node_offset", e.off1, o_second_node_offset);
                check_field("second_bytes", e.size1, o_second_bytes);
                check_field("first_stripe", e.stripe0, o_first_stripe);
                check_field("second_stripe", e.stripe1, o_second_stripe);
                check_field("stripe_count", e.nstripes, o_stripe_count);
            end
        end
    end

    // Presents one item and holds it until the block takes it.
    task automatic send_item(logic req, logic cls, logic [63:0] addr,
                             logic [7:0] w, logic [7:0] src, logic lk);
        start            <= 1'b1;
        i_req_type       <= req;
        i_access_class   <= cls;
        i_address        <= addr;
        i_access_width   <= w;
        i_source_size    <= src;
        i_already_locked <= lk;
        do @(posedge i_clk); while (busy);
        pending_routes.push_back(predict_route(req, cls, addr, w, src, lk));
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_routes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [63:0] value);
        drain_results();
        repeat (16) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE:  cfg_base  = value;
            REG_SIZE:  cfg_size  = value;
            REG_NODES: cfg_nodes = value[8:0];
            REG_LOCAL: cfg_local = value[7:0];
        endcase
    endtask

    task automatic set_config(logic [63:0] base, logic [63:0] size,
                              logic [8:0] nodes, logic [7:0] local_id);
        write_reg(REG_BASE, base);
        write_reg(REG_SIZE, size);
        write_reg(REG_NODES, {55'd0, nodes});
        write_reg(REG_LOCAL, {56'd0, local_id});
    endtask

    // A well-formed load or store: matched class, matched size, no lock.
    task automatic send_clean(logic [63:0] addr, logic [7:0] w);
        logic req;
        req = 1'($urandom_range(0, 1));
        send_item(req, req, addr, w, w, 1'b0);
    endtask

    // One random item. Most land near node and line boundaries of the region;
    // the rest are noise with every field random.
    task automatic send_random(bit allow_idle);
        logic [63:0] ns;
        logic [63:0] span;
        logic [63:0] nb;
        logic [63:0] off;
        logic [63:0] addr;
        logic [7:0]  w;
        logic        req;
        logic        cls;
        logic [7:0]  src;
        int          k;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        if ($urandom_range(0, 9) < 2) begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end
        w = 8'($urandom_range(1, 64));
        if (cfg_nodes != 0 && cfg_nodes <= MAX_NODES && cfg_size / cfg_nodes != 0) begin
            ns   = cfg_size / cfg_nodes;
            k    = $urandom_range(0, cfg_nodes - 1);
            nb   = cfg_base + k * ns;
            span = (k == cfg_nodes - 1) ? cfg_size - k * ns : ns;
            case ($urandom_range(0, 3))
                0: off = 64'($urandom_range(0, 127));
                1: off = span - w - $urandom_range(0, 127);
                2: off = {$urandom, $urandom} % span;
                default: off = span - w + $urandom_range(0, 8);
            endcase
            addr = nb + off;
        end else begin
            addr = cfg_base + $urandom_range(0, 255) - 64;
        end
        req = 1'($urandom_range(0, 1));
        cls = ($urandom_range(0, 15) == 0) ? ~req : req;
        src = (req && $urandom_range(0, 15) != 0) ? w : 8'($urandom_range(0, 255));
        send_item(req, cls, addr, w, src, $urandom_range(0, 15) == 0);
    endtask

    // Reset values: region size zero, so every access is out of range.
    task automatic test_reset_config();
        send_clean(64'h0, 8'd8);
        send_clean(64'h40, 8'd64);
    endtask

    // Request checks, range classes, node crossing and line splitting.
    task automatic test_directed();
        set_config(64'h1000, 64'h4000, 9'd4, 8'd2);
        send_item(1'b1, 1'b1, 64'h1000, 8'd8, 8'd4, 1'b0);   // store size mismatch
        send_item(1'b0, 1'b0, 64'h1000, 8'd8, 8'd4, 1'b0);   // load ignores source size
        send_item(1'b0, 1'b0, 64'h1000, 8'd8, 8'd8, 1'b1);   // locks still held
        send_item(1'b0, 1'b1, 64'h1000, 8'd8, 8'd8, 1'b0);   // class differs
        send_item(1'b1, 1'b0, 64'h1000, 8'd8, 8'd8, 1'b0);
        send_clean(64'h1000, 8'd0);                          // zero width
        send_clean(64'h1000, 8'd65);
        send_clean(64'h1000, 8'd255);
        send_clean(64'hFFFF_FFFF_FFFF_FFF0, 8'd32);          // address wraps
        send_clean(64'h0F00, 8'd8);                          // below the region
        send_clean(64'h0FFC, 8'd8);                          // straddles the start
        send_clean(64'h4FFC, 8'd8);                          // straddles the end
        send_clean(64'h5000, 8'd1);                          // beyond the end
        send_clean(64'h1FFC, 8'd8);                          // crosses a node boundary
        send_clean(64'h1000, 8'd64);                         // one full line
        send_clean(64'h1001, 8'd64);                         // two segments
        send_clean(64'h203F, 8'd2);                          // split after one byte
        send_clean(64'h4FC0, 8'd64);                         // last byte line
        send_clean(64'h3FF8, 8'd8);
    endtask

    // Node count zero, above the maximum, node size zero, region end wraps.
    task automatic test_bad_config();
        set_config(64'h0, 64'h1_0000, 9'd0, 8'd0);
        send_clean(64'h100, 8'd4);
        write_reg(REG_NODES, 64'd257);
        send_clean(64'h100, 8'd4);
        write_reg(REG_NODES, 64'd511);
        send_clean(64'h100, 8'd4);
        set_config(64'h0, 64'd5, 9'd10, 8'd0);
        send_clean(64'h1, 8'd2);
        set_config(64'hFFFF_FFFF_FFFF_0000, 64'h2_0000, 9'd2, 8'd1);
        send_clean(64'hFFFF_FFFF_FFFF_0010, 8'd4);
    endtask

    // Random items over a range of register settings, extremes included.
    task automatic test_random();
        logic [63:0] bases [8];
        logic [63:0] sizes [8];
        logic [8:0]  nodes [8];
        logic [7:0]  locals [8];
        bases  = '{64'h0, 64'hFFFF_FFFF_FFFF_0000, {$urandom, $urandom} >> 2, 64'd100,
                   64'h0, 64'h8000_0000_0000_0000, 64'h0, 64'h10_0000};
        sizes  = '{64'h10_0000, 64'h1_0000, 64'h10_0000_0000, 64'd1000,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd300, 64'h4_0000};
        nodes  = '{9'd4, 9'd256, $urandom_range(1, 256), 9'd3, 9'd1, 9'd255, 9'd256, 9'd7};
        locals = '{8'd1, 8'd255, $urandom_range(0, 255), 8'd2, 8'd0, 8'd128, 8'd9, 8'd6};
        for (int p = 0; p < 8; p++) begin
            set_config(bases[p], sizes[p], nodes[p], locals[p]);
            for (int n = 0; n < 80; n++) begin
                send_random(p != 7);
                if (p == 3 && n == 40) drain_results();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_directed();
        test_bad_config();
        test_random();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/pasr_pkg.sv
rtl/pasr_cfg_div.sv
rtl/pasr_div_stage.sv
rtl/pgas_access_route_and_split_core.sv
tb/testbench.sv
